FILE: design/cbsu_pkg.sv
// cbsu_pkg: shared types and constants for the cubic b-spline 5x upsampler
// holds the phase weight table, field widths and counter types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cbsu_pkg;

	localparam int SAMPLE_W = 8;
	localparam int LEVEL_W  = 18;
	localparam int WEIGHT_W = 9;
	localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
	localparam int PHASES   = 5;
	localparam int TAPS     = 4;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [LEVEL_W-1:0]  level_t;
	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef logic [PROD_W-1:0]   prod_t;
	typedef logic [2:0]          phase_t;
	typedef logic [1:0]          group_t;

	localparam phase_t PHASE_FIRST = 3'd0;
	localparam phase_t PHASE_LAST  = 3'd4;

	// groups still to come after the current one
	localparam group_t GROUPS_NONE      = 2'd0;
	localparam group_t GROUPS_FLUSH     = 2'd2;
	localparam group_t GROUPS_RUN_FLUSH = 2'd3;

	// largest possible weighted sum: 255 * 750
	localparam level_t LEVEL_MAX = 18'd191250;

	// b-spline weights times 750, taps oldest to newest, one row per phase
	localparam weight_t WEIGHTS [PHASES][TAPS] = '{
		'{9'd125, 9'd500, 9'd125, 9'd0},
		'{9'd64,  9'd473, 9'd212, 9'd1},
		'{9'd27,  9'd404, 9'd311, 9'd8},
		'{9'd8,   9'd311, 9'd404, 9'd27},
		'{9'd1,   9'd212, 9'd473, 9'd64}
	};

endpackage

`default_nettype wire

FILE: design/cubic_bspline_upsample_by_five.sv
// cubic_bspline_upsample_by_five: top level of the 5x cubic b-spline upsampler
// depends on cbsu_pkg for the weight table, widths and counter types
`timescale 1ns / 1ps
`default_nettype none

//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  input   | in        | in_valid / in_stall  | sample, block_end
//  result  | out       | out_valid / out_stall| level_sum, run_end, frame_end
//
// one result word leaves per cycle while the result side does not stall, one phase of the four-tap dot product each;
// a sample mid-block yields one group of five results, the last sample of a block four groups
// (three when it is also the first), the first sample of a longer block none;
// all come from the single shared weighting unit behind the window register
// arst_n clears the walk state (busy, phase, groups), the history and the result valid, not the window taps
// a stalled result holds in the output register and the phase walk holds with it;
// the next input word is taken in the cycle the current word's final result issues
module cubic_bspline_upsample_by_five (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire cbsu_pkg::sample_t sample,
	input  wire                   block_end,
	output logic                  out_valid,
	input  wire                   out_stall,
	output cbsu_pkg::level_t      level_sum,
	output logic                  run_end,
	output logic                  frame_end
);
	import cbsu_pkg::*;

	// history of the block: hist0_q newest
	sample_t hist0_q;
	sample_t hist1_q;
	sample_t hist2_q;
	logic    in_block_q;

	// window register: four taps, oldest first, and the phase walk over them
	sample_t win_q [TAPS];
	logic    last_q;
	logic    busy_q;
	phase_t  phase_q;
	group_t  groups_q;

	// output register
	logic    out_valid_q;
	level_t  level_sum_q;
	logic    run_end_q;
	logic    frame_end_q;

	logic    adv;
	logic    issue;
	logic    final_res;
	logic    group_done;
	logic    accept;
	prod_t   prod [TAPS];
	level_t  acc;

	// output register can load when empty or being drained
	assign adv        = !out_valid_q || !out_stall;
	assign issue      = busy_q && adv;
	assign group_done = phase_q == PHASE_LAST;
	assign final_res  = group_done && (groups_q == GROUPS_NONE);

	// take a new word when idle or when the current word issues its final result
	assign in_stall = busy_q && !(issue && final_res);
	assign accept   = in_valid && !in_stall;

	// weighted sum for the current phase
	always_comb begin
		acc = '0;
		for (int t = 0; t < TAPS; t++) begin
			prod[t] = PROD_W'(win_q[t]) * PROD_W'(WEIGHTS[phase_q][t]);
			acc     = acc + LEVEL_W'(prod[t]);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist0_q     <= '0;
			hist1_q     <= '0;
			hist2_q     <= '0;
			in_block_q  <= 1'b0;
			busy_q      <= 1'b0;
			phase_q     <= PHASE_FIRST;
			groups_q    <= GROUPS_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= busy_q;
			end
			if (accept) begin
				// first word of a block refills the history with itself
				hist0_q    <= sample;
				hist1_q    <= in_block_q ? hist0_q : sample;
				hist2_q    <= in_block_q ? hist1_q : sample;
				in_block_q <= !block_end;
				busy_q     <= in_block_q || block_end;
				phase_q    <= PHASE_FIRST;
				if (in_block_q) begin
					groups_q <= block_end ? GROUPS_RUN_FLUSH : GROUPS_NONE;
				end else begin
					groups_q <= GROUPS_FLUSH;
				end
			end else if (issue) begin
				// a word is only taken alongside the final result, so it owns the walk
				if (group_done) begin
					phase_q <= PHASE_FIRST;
					if (groups_q != GROUPS_NONE) begin
						groups_q <= groups_q - 2'd1;
					end else begin
						busy_q <= 1'b0;
					end
				end else begin
					phase_q <= phase_q + 3'd1;
				end
			end
		end
	end

	// window and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			last_q <= block_end;
			if (in_block_q) begin
				win_q[0] <= hist2_q;
				win_q[1] <= hist1_q;
				win_q[2] <= hist0_q;
				win_q[3] <= sample;
			end else begin
				for (int t = 0; t < TAPS; t++) begin
					win_q[t] <= sample;
				end
			end
		end else if (issue && group_done && (groups_q != GROUPS_NONE)) begin
			// flush: slide one tap, clamping with the last sample
			for (int t = 0; t < TAPS - 1; t++) begin
				win_q[t] <= win_q[t+1];
			end
			win_q[TAPS-1] <= win_q[TAPS-1];
		end
		if (issue) begin
			level_sum_q <= acc;
			run_end_q   <= final_res;
			frame_end_q <= final_res && last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign level_sum = level_sum_q;
	assign run_end   = run_end_q;
	assign frame_end = frame_end_q;

`ifndef SYNTHESIS
	// the block end always closes the word's run
	a_frame_implies_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!frame_end || run_end))
		else $error("frame_end without run_end");

	// phase walk stays within the five phases
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (phase_q <= PHASE_LAST))
		else $error("phase out of range");

	// a block end leaves the history ready for a fresh block
	a_block_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && block_end) |=> !in_block_q)
		else $error("block not closed after block end");

	// weighted sum never exceeds full scale
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (level_sum <= LEVEL_MAX))
		else $error("level sum above full scale");
`endif

endmodule

`default_nettype wire

FILE: sim/cubic_bspline_upsample_by_five_tb.sv
// cubic_bspline_upsample_by_five_tb: self-checking bench for the 5x cubic b-spline upsampler
// directed and random sample blocks, a scoreboard class predicts every smoothed level word
// depends on cbsu_pkg and cubic_bspline_upsample_by_five
`timescale 1ns / 1ps

module cubic_bspline_upsample_by_five_tb;

	import cbsu_pkg::*;

	// spline weights times 750 per phase, taps from oldest to newest sample
	localparam int unsigned SPLINE_WT [5][4] = '{
		'{125, 500, 125, 0},
		'{64, 473, 212, 1},
		'{27, 404, 311, 8},
		'{8, 311, 404, 27},
		'{1, 212, 473, 64}
	};

	localparam int RANDOM_WORDS = 420;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		level_t level;
		bit     run;
		bit     frame;
	} level_word_t;

	// predicts the level words of each accepted sample and checks them in order
	class spline_scoreboard;
		level_word_t expected_q[$];
		sample_t     hist [3];
		bit          in_blk;
		int          mismatches;

		function void push_group(sample_t win [4]);
			int unsigned acc;
			level_word_t w;
			for (int k = 0; k < 5; k++) begin
				acc = 0;
				for (int t = 0; t < 4; t++)
					acc += int'(win[t]) * SPLINE_WT[k][t];
				w.level = acc[LEVEL_W-1:0];
				w.run   = 1'b0;
				w.frame = 1'b0;
				expected_q.push_back(w);
			end
		endfunction

		function void note_word(sample_t s, bit last);
			sample_t win [4];
			int      base;
			base = expected_q.size();
			if (!in_blk) begin
				// block start: edges clamp to the first sample
				hist = '{s, s, s};
				win  = '{s, s, s, s};
			end else begin
				win = '{hist[2], hist[1], hist[0], s};
				push_group(win);
			end
			hist[2] = hist[1];
			hist[1] = hist[0];
			hist[0] = s;
			in_blk  = 1'b1;
			if (last) begin
				// flush the tail, clamped to the last sample
				for (int g = 0; g < 3; g++) begin
					win = '{win[1], win[2], win[3], s};
					push_group(win);
				end
				in_blk = 1'b0;
			end
			if (expected_q.size() > base) begin
				expected_q[expected_q.size()-1].run   = 1'b1;
				expected_q[expected_q.size()-1].frame = last;
			end
		endfunction

		function void check_word(level_t level, bit run, bit frame);
			level_word_t w;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected level word: %0d run_end %b frame_end %b",
						level, run, frame);
				return;
			end
			w = expected_q.pop_front();
			if (w.level !== level || w.run !== run || w.frame !== frame) begin
				mismatches++;
				if (mismatches <= 10)
					$display("level word mismatch: expected %0d/%b/%b, got %0d/%b/%b",
						w.level, w.run, w.frame, level, run, frame);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_stall;
	sample_t sample;
	logic    block_end;
	logic    out_valid;
	logic    out_stall;
	level_t  level_sum;
	logic    run_end;
	logic    frame_end;

	spline_scoreboard sb = new();

	// shared between the two sides: calm switches off random idling on both,
	// hold_off_req asks the result side for one long stall
	bit calm;
	bit hold_off_req;
	int words_sent;

	cubic_bspline_upsample_by_five DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.block_end (block_end),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.level_sum (level_sum),
		.run_end   (run_end),
		.frame_end (frame_end)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard limit, far beyond the slowest correct run
	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

	// result side: random stalls, one long hold-off counted here
	initial begin : result_side
		int hold_cnt;
		hold_cnt  = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_cnt     = LONG_HOLD;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 33);
			end
		end
	end

	// every word taken on the result channel goes straight to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word(level_sum, run_end, frame_end);
	end

	// offers one sample word, idling at random first, and waits until it is taken
	task automatic send_word(input sample_t s, input bit last);
		while (!calm && $urandom_range(0, 99) < 33) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		sample    <= s;
		block_end <= last;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_word(s, last);
		words_sent++;
	endtask

	task automatic send_block(input sample_t vals [$]);
		foreach (vals[i])
			send_word(vals[i], i == vals.size() - 1);
	endtask

	// mostly full-range bytes, with the extremes now and then
	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return sample_t'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin : stimulus
		sample_t blk [$];
		int      len;
		bit      hold_done;
		bit      pause_done;

		arst_n     = 1'b0;
		in_valid   = 1'b0;
		sample     = '0;
		block_end  = 1'b0;
		calm       = 1'b0;
		words_sent = 0;
		hold_done  = 1'b0;
		pause_done = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single-sample blocks at both extremes, then short blocks
		// where the clamped edges overlap and every sample bit flips
		blk = '{8'd0};
		send_block(blk);
		blk = '{8'd255};
		send_block(blk);
		blk = '{8'd0, 8'd255};
		send_block(blk);
		blk = '{8'd255, 8'd0, 8'd255};
		send_block(blk);
		blk = '{8'd128, 8'd127, 8'd1, 8'd254, 8'd85, 8'd170};
		send_block(blk);
		blk = '{8'd255, 8'd255, 8'd255, 8'd255};
		send_block(blk);
		blk = '{8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64};
		send_block(blk);

		// random blocks, mostly short, now and then a long one
		while (words_sent < RANDOM_WORDS) begin
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(20, 40);
			else
				len = $urandom_range(1, 10);
			blk.delete();
			repeat (len)
				blk.push_back(pick_sample());

			// fill the block up behind a long result stall while words keep coming
			if (!hold_done && words_sent > 120) begin
				hold_done    = 1'b1;
				hold_off_req = 1'b1;
			end
			// sender waits until every predicted word has come out
			if (!pause_done && words_sent > 250) begin
				pause_done = 1'b1;
				in_valid  <= 1'b0;
				while (sb.pending() != 0)
					@(posedge clk);
			end
			// a stretch with no idling on either side
			calm = (words_sent > 300 && words_sent < 370);

			send_block(blk);
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		// catch any stray words after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
